[rtl/core/awbq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// awbq_pkg: shared types and constants of the A-weighting biquad cascade
// Sample and delay-word formats, controller steps, the command struct and
// the fixed Q2.30 coefficient set.
// ----------------------------------------------------------------------------
package awbq_pkg;

	// sample format, Q1.23
	localparam int SAMPLE_W    = 24;
	// coefficient format, Q2.30 in a 32-bit word, magnitude below 2^31
	localparam int COEF_W      = 32;
	localparam int COEF_MAG_W  = 31;
	localparam int COEF_FRAC   = 30;
	// delay words, Q5.35
	localparam int DELAY_W     = 40;
	localparam int DELAY_FRAC  = 35;
	// product magnitude and its scaling down to delay fraction bits
	localparam int PROD_W      = SAMPLE_W + COEF_MAG_W;
	localparam int PROD_SHIFT  = SAMPLE_W - 1 + COEF_FRAC - DELAY_FRAC;
	localparam int SCALED_W    = PROD_W + 1 - PROD_SHIFT;
	// wide enough for any delay-word sum before saturation
	localparam int SUM_W       = DELAY_W + 2;
	// shift from delay format to sample format
	localparam int OUT_SHIFT   = DELAY_FRAC - (SAMPLE_W - 1);
	// section index as carried in the command
	localparam int SEC_IDX_W   = 3;
	localparam int TABLE_SECS  = 3;
	localparam int TDATA_W     = ((SAMPLE_W + 7) / 8) * 8;

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< COEF_FRAC);

	// what tuser asks of the filter
	typedef enum logic {
		OP_FILTER,
		OP_CLEAR
	} awbq_op_t;

	// controller steps; ST_B0 to ST_FIN run one per cycle for each section
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_A1,
		ST_A2,
		ST_FIN,
		ST_DONE
	} state_t;

	// coefficient selector within a section
	typedef enum logic [2:0] {
		K_B0,
		K_B1,
		K_B2,
		K_A1,
		K_A2
	} coef_sel_t;

	// controller to datapath commands
	typedef struct packed {
		state_t                 step;
		logic [SEC_IDX_W-1:0]   sec;
		logic                   load;
		logic                   clear;
		logic                   done;
	} ctl_cmd_t;

	// delay words of one section
	typedef struct packed {
		logic signed [DELAY_W-1:0] z2;
		logic signed [DELAY_W-1:0] z1;
	} delay_row_t;

	// finished result of one item
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clip;
		logic                       last;
	} result_t;

	// b0, b1, b2, a1, a2 of the three weighting sections
	localparam logic signed [COEF_W-1:0] COEF_TABLE [TABLE_SECS][5] = '{
		'{ 32'sd1070852429, -32'sd2141704857, 32'sd1070852429,
		  -32'sd2141700964,  32'sd1067966926 },
		'{ 32'sd1017110067, -32'sd2034220133, 32'sd1017110067,
		  -32'sd2033527959,  32'sd961170483 },
		'{ 32'sd266169001,   32'sd532338003,  32'sd266169001,
		  -32'sd241117808,   32'sd13536261 }
	};

	// coefficient lookup; sections past the table pass the sample through
	function automatic logic signed [COEF_W-1:0] coef_value(
		input logic [SEC_IDX_W-1:0] sec,
		input coef_sel_t            k
	);
		logic signed [COEF_W-1:0] c;
		if (sec < SEC_IDX_W'(TABLE_SECS)) begin
			c = COEF_TABLE[sec[1:0]][k];
		end else if (k == K_B0) begin
			c = COEF_ONE;
		end else begin
			c = '0;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/core/awbq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// awbq_ctrl: sequencer of the biquad cascade
// Steps each accepted filter item through B0, B1, B2, A1, A2 and FIN of every
// section, sends a clear item straight to done, and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module awbq_ctrl
	import awbq_pkg::*;
#(
	parameter int SECTION_COUNT = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_clear,
	input  wire logic out_free,
	output logic      in_ready,
	output ctl_cmd_t  cmd
);

	localparam int SEC_W = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;

	state_t           state_q, state_d;
	logic [SEC_W-1:0] sec_q, sec_d;

	// state and section counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= '0;
		end else begin
			state_q <= state_d;
			sec_q   <= sec_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		sec_d     = sec_q;
		in_ready  = 1'b0;
		cmd.step  = state_q;
		cmd.sec   = SEC_IDX_W'(sec_q);
		cmd.load  = 1'b0;
		cmd.clear = 1'b0;
		cmd.done  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					sec_d    = '0;
					if (in_clear) begin
						cmd.clear = 1'b1;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_B0;
					end
				end
			end
			ST_B0: state_d = ST_B1;
			ST_B1: state_d = ST_B2;
			ST_B2: state_d = ST_A1;
			ST_A1: state_d = ST_A2;
			ST_A2: state_d = ST_FIN;
			ST_FIN: begin
				if (sec_q == SEC_W'(SECTION_COUNT - 1)) begin
					sec_d   = '0;
					state_d = ST_DONE;
				end else begin
					sec_d   = SEC_W'(sec_q + 1'b1);
					state_d = ST_B0;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/awbq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// awbq_datapath: shared multiplier, accumulators and delay words
// One product is issued per step and scaled and summed in the next step;
// the section output is rounded and saturated from the registered b0 sum.
// ----------------------------------------------------------------------------
module awbq_datapath
	import awbq_pkg::*;
#(
	parameter int SECTION_COUNT = 3
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctl_cmd_t                   cmd,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic                       last_in,
	output result_t                         res
);

	localparam int SEC_W = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
	localparam logic [PROD_W:0] PROD_ROUND = (PROD_W + 1)'(1) << (PROD_SHIFT - 1);
	localparam logic signed [SUM_W-1:0] DELAY_MAX =
		{{(SUM_W - DELAY_W + 1){1'b0}}, {(DELAY_W - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] DELAY_MIN =
		{{(SUM_W - DELAY_W + 1){1'b1}}, {(DELAY_W - 1){1'b0}}};
	localparam logic signed [DELAY_W:0] Y_ROUND = (DELAY_W + 1)'(1) << (OUT_SHIFT - 1);
	localparam logic signed [DELAY_W:0] Y_MAX =
		{{(DELAY_W - SAMPLE_W + 2){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [DELAY_W:0] Y_MIN =
		{{(DELAY_W - SAMPLE_W + 2){1'b1}}, {(SAMPLE_W - 1){1'b0}}};

	// clamp a sum to the delay-word range
	function automatic logic signed [DELAY_W-1:0] sat_delay(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [SUM_W-1:0] r;
		if (v > DELAY_MAX) begin
			r = DELAY_MAX;
		end else if (v < DELAY_MIN) begin
			r = DELAY_MIN;
		end else begin
			r = v;
		end
		return r[DELAY_W-1:0];
	endfunction

	delay_row_t                 delay_q [SECTION_COUNT];
	logic signed [SAMPLE_W-1:0] x_q, y_q;
	logic                       clip_q, last_q;
	logic [PROD_W-1:0]          prod_q;
	logic                       prod_neg_q;
	logic signed [DELAY_W-1:0]  acc_q, z1n_q;
	logic signed [SUM_W-1:0]    t1_q, t2_q;

	logic [SEC_W-1:0]           sec;
	delay_row_t                 row;
	coef_sel_t                  ksel;
	logic signed [SAMPLE_W-1:0] mul_a, neg_a;
	logic signed [COEF_W-1:0]   mul_c, neg_c;
	logic [SAMPLE_W-1:0]        a_mag;
	logic [COEF_MAG_W-1:0]      c_mag;
	logic [PROD_W-1:0]          prod_d;
	logic [PROD_W:0]            prod_rnd;
	logic [SCALED_W-1:0]        p_mag;
	logic signed [SCALED_W-1:0] p_val;
	logic signed [SUM_W-1:0]    p_ext;
	logic signed [SUM_W-1:0]    acc_sum, t1_sum, z1_sum, z2_sum;
	logic signed [DELAY_W:0]    y_rnd, y_shift;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic                       y_clip;

	assign sec = cmd.sec[SEC_W-1:0];
	assign row = delay_q[sec];

	// operand and coefficient selection for the shared multiplier
	always_comb begin
		unique case (cmd.step)
			ST_B1:   ksel = K_B1;
			ST_B2:   ksel = K_B2;
			ST_A1:   ksel = K_A1;
			ST_A2:   ksel = K_A2;
			default: ksel = K_B0;
		endcase
		mul_a = ((cmd.step == ST_A1) || (cmd.step == ST_A2)) ? y_q : x_q;
		mul_c = coef_value(cmd.sec, ksel);
	end

	// sign-magnitude multiply
	assign neg_a  = -mul_a;
	assign neg_c  = -mul_c;
	assign a_mag  = mul_a[SAMPLE_W-1] ? neg_a : mul_a;
	assign c_mag  = mul_c[COEF_W-1] ? neg_c[COEF_MAG_W-1:0] : mul_c[COEF_MAG_W-1:0];
	assign prod_d = PROD_W'(a_mag) * PROD_W'(c_mag);

	// scale product to delay format, rounding half away from zero
	assign prod_rnd = {1'b0, prod_q} + PROD_ROUND;
	assign p_mag    = prod_rnd[PROD_W:PROD_SHIFT];
	assign p_val    = prod_neg_q ? -$signed(p_mag) : $signed(p_mag);
	assign p_ext    = SUM_W'(p_val);

	// delay-word sums
	assign acc_sum = p_ext + SUM_W'($signed(row.z1));
	assign t1_sum  = p_ext + SUM_W'($signed(row.z2));
	assign z1_sum  = t1_q - p_ext;
	assign z2_sum  = t2_q - p_ext;

	// section output: round to sample precision and saturate
	always_comb begin
		y_rnd   = (DELAY_W + 1)'(acc_q) + Y_ROUND;
		y_shift = y_rnd >>> OUT_SHIFT;
		y_clip  = 1'b0;
		if (y_shift > Y_MAX) begin
			y_sat  = Y_MAX[SAMPLE_W-1:0];
			y_clip = 1'b1;
		end else if (y_shift < Y_MIN) begin
			y_sat  = Y_MIN[SAMPLE_W-1:0];
			y_clip = 1'b1;
		end else begin
			y_sat = y_shift[SAMPLE_W-1:0];
		end
	end

	// filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SECTION_COUNT; i++) begin
				delay_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < SECTION_COUNT; i++) begin
				delay_q[i] <= '0;
			end
		end else if (cmd.step == ST_FIN) begin
			delay_q[sec].z1 <= z1n_q;
			delay_q[sec].z2 <= sat_delay(z2_sum);
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		prod_q     <= prod_d;
		prod_neg_q <= mul_a[SAMPLE_W-1] ^ mul_c[COEF_W-1];
		if (cmd.load) begin
			x_q    <= cmd.clear ? '0 : sample_in;
			last_q <= last_in;
			clip_q <= 1'b0;
		end
		unique case (cmd.step)
			ST_B1: acc_q <= sat_delay(acc_sum);
			ST_B2: begin
				t1_q   <= t1_sum;
				y_q    <= y_sat;
				clip_q <= clip_q | y_clip;
			end
			ST_A1:  t2_q  <= p_ext;
			ST_A2:  z1n_q <= sat_delay(z1_sum);
			ST_FIN: x_q   <= y_q;
			default: ;
		endcase
	end

	assign res.sample = x_q;
	assign res.clip   = clip_q;
	assign res.last   = last_q;

endmodule
`default_nettype wire

[rtl/core/a_weighting_biquad_cascade_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// a_weighting_biquad_cascade_unit: A-weighting filter, 48 kHz, biquad cascade
// Filters one sample per item through SECTION_COUNT transposed direct form II
// sections on a single shared multiplier; a clear item zeroes the history.
// ----------------------------------------------------------------------------
// sequence: an accepted item runs through the steps of every section, then
//   the done step loads the output register; a clear item goes straight to done
// flow: a new item is taken only once the last has left for the output register;
//   each section takes six steps (five products on the one multiplier and a
//   write-back), and a result held by m_tready low delays the next accept
// reset: arst_n clears all delay words and empties the output register
// ----------------------------------------------------------------------------
module a_weighting_biquad_cascade_unit
	import awbq_pkg::*;
#(
	parameter int SECTION_COUNT = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,   // [23:0] sample_in
	input  wire logic               s_tuser,   // [0] opcode
	input  wire logic               s_tlast,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [TDATA_W-1:0]      m_tdata,   // [23:0] sample_out
	output logic                    m_tuser,   // [0] clipped
	output logic                    m_tlast
);

	ctl_cmd_t cmd;
	result_t  res;
	logic     out_free;
	logic     valid_q;
	result_t  out_q;

	assign out_free = !valid_q || m_tready;

	awbq_ctrl #(
		.SECTION_COUNT(SECTION_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_clear (s_tuser == OP_CLEAR),
		.out_free (out_free),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	awbq_datapath #(
		.SECTION_COUNT(SECTION_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample_in ($signed(s_tdata[SAMPLE_W-1:0])),
		.last_in   (s_tlast),
		.res       (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.done) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			out_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = TDATA_W'(unsigned'(out_q.sample));
	assign m_tuser  = out_q.clip;
	assign m_tlast  = out_q.last;

endmodule
`default_nettype wire

[dv/awbq_weighting_checker.sv]
// ----------------------------------------------------------------------------
// awbq_weighting_checker: scoreboard for the A-weighting biquad cascade
// Watches both stream channels. Every accepted input item is run through a
// bit-exact fixed-point model of the three weighting sections. Each accepted
// output item is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module awbq_weighting_checker
	import awbq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [23:0] sample_in
	input  logic               s_tuser,   // [0] opcode
	input  logic               s_tlast,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,   // [23:0] sample_out
	input  logic               m_tuser,   // [0] clipped
	input  logic               m_tlast,
	output int                 outstanding,
	output int                 mismatch_total
);

	localparam int STAGES        = 3;
	// sample Q1.23 times coefficient Q2.30, scaled down to Q5.35
	localparam int PRODUCT_SHIFT = 23 + 30 - 35;
	// delay word Q5.35 back to sample Q1.23
	localparam int OUT_SHIFT_BITS = 35 - 23;
	localparam longint Z_MAX      = (64'sd1 <<< 39) - 1;
	localparam longint Z_MIN      = -(64'sd1 <<< 39);
	localparam longint SMP_MAX    = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint SMP_MIN    = -(64'sd1 <<< (SAMPLE_W - 1));

	// b0, b1, b2, a1, a2 per section, Q2.30
	localparam longint WEIGHT_COEF [STAGES][5] = '{
		'{ 64'sd1070852429, -64'sd2141704857, 64'sd1070852429,
		  -64'sd2141700964,  64'sd1067966926 },
		'{ 64'sd1017110067, -64'sd2034220133, 64'sd1017110067,
		  -64'sd2033527959,  64'sd961170483 },
		'{ 64'sd266169001,   64'sd532338003,  64'sd266169001,
		  -64'sd241117808,   64'sd13536261 }
	};

	// z1 of section k at 2k, z2 at 2k+1
	longint  section_z [2*STAGES];
	result_t weighted_due [$];
	int      fault_count;

	assign mismatch_total = fault_count;

	// magnitude product, rounded half away from zero, sign put back after
	function automatic longint scaled_product(input longint a, input longint b);
		longint unsigned ua;
		longint unsigned ub;
		longint unsigned m;
		ua = (a < 0) ? longint'(-a) : a;
		ub = (b < 0) ? longint'(-b) : b;
		m  = (ua * ub + (64'd1 << (PRODUCT_SHIFT - 1))) >> PRODUCT_SHIFT;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp_delay(input longint v);
		if (v > Z_MAX) begin
			return Z_MAX;
		end
		if (v < Z_MIN) begin
			return Z_MIN;
		end
		return v;
	endfunction

	// runs one item through the cascade and updates the delay words
	function automatic result_t weigh_sample(
		input awbq_op_t                   op,
		input logic signed [SAMPLE_W-1:0] x_in,
		input logic                       last
	);
		result_t r;
		longint  x;
		longint  y;
		longint  acc;
		logic    clip;
		r.last = last;
		clip   = 1'b0;
		x      = x_in;
		if (op == OP_CLEAR) begin
			foreach (section_z[i]) section_z[i] = 0;
			r.sample = '0;
			r.clip   = 1'b0;
			return r;
		end
		for (int s = 0; s < STAGES; s++) begin
			acc = clamp_delay(scaled_product(x, WEIGHT_COEF[s][K_B0]) + section_z[2*s]);
			y   = (acc + (64'sd1 <<< (OUT_SHIFT_BITS - 1))) >>> OUT_SHIFT_BITS;
			if (y > SMP_MAX) begin
				y    = SMP_MAX;
				clip = 1'b1;
			end
			if (y < SMP_MIN) begin
				y    = SMP_MIN;
				clip = 1'b1;
			end
			section_z[2*s]   = clamp_delay(scaled_product(x, WEIGHT_COEF[s][K_B1])
				- scaled_product(y, WEIGHT_COEF[s][K_A1]) + section_z[2*s+1]);
			section_z[2*s+1] = clamp_delay(scaled_product(x, WEIGHT_COEF[s][K_B2])
				- scaled_product(y, WEIGHT_COEF[s][K_A2]));
			x = y;
		end
		r.sample = x[SAMPLE_W-1:0];
		r.clip   = clip;
		return r;
	endfunction

	task automatic flag_fault(input string why, input result_t want, input result_t got);
		if (fault_count < 10) begin
			$display({"awbq check: %s at %0t: expected sample %0d clip %0b last %0b,",
				" got sample %0d clip %0b last %0b"},
				why, $realtime, want.sample, want.clip, want.last,
				got.sample, got.clip, got.last);
		end
		fault_count++;
	endtask

	// outputs are checked before this edge's input is queued
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			foreach (section_z[i]) section_z[i] = 0;
			weighted_due.delete();
			fault_count = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.sample = m_tdata[SAMPLE_W-1:0];
				got.clip   = m_tuser;
				got.last   = m_tlast;
				if (weighted_due.size() == 0) begin
					flag_fault("result with nothing awaited", '0, got);
				end else begin
					want = weighted_due.pop_front();
					if (got.sample !== want.sample || got.clip !== want.clip ||
					    got.last !== want.last) begin
						flag_fault("mismatch", want, got);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				weighted_due.push_back(weigh_sample(awbq_op_t'(s_tuser),
					$signed(s_tdata[SAMPLE_W-1:0]), s_tlast));
			end
			outstanding <= weighted_due.size();
		end
	end

endmodule

[dv/a_weighting_biquad_cascade_unit_test.sv]
// ----------------------------------------------------------------------------
// a_weighting_biquad_cascade_unit_test: stimulus and verdict for the filter
// Drives directed extremes, clears and a clipping square burst, then random
// blocks of noise, square bursts, quiet noise, DC runs and clears, with
// random idling on both stream sides; the checker does the comparison.
// ----------------------------------------------------------------------------
module a_weighting_biquad_cascade_unit_test;
	import awbq_pkg::*;

	localparam int ITEM_TARGET = 725;
	localparam int FULL_POS    = 8388607;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata;   // [23:0] sample_in
	logic               s_tuser;   // [0] opcode
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;   // [23:0] sample_out
	logic               m_tuser;   // [0] clipped
	logic               m_tlast;
	logic               steady;
	int                 outstanding;
	int                 mismatch_total;
	int                 sent;

	a_weighting_biquad_cascade_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	awbq_weighting_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.outstanding    (outstanding),
		.mismatch_total (mismatch_total)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#4000000;
		$display("a_weighting_biquad_cascade_unit_test: errors");
		$finish;
	end

	// output side backpressure
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= steady || ($urandom_range(0, 99) >= 35);
		end
	end

	// one item, then maybe an idle gap; items 350 to 449 go without idling
	task automatic send_item(input awbq_op_t op, input int value, input logic last);
		steady   <= (sent >= 350 && sent < 450);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= TDATA_W'(SAMPLE_W'(value));
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (!(sent >= 350 && sent < 450) && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// hold the input side until every awaited result is out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// stimulus and verdict
	initial begin
		int   kind;
		int   span;
		int   half;
		int   level;
		int   value;
		logic paused;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= OP_FILTER;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		steady   <= 1'b0;
		sent      = 0;
		paused    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clear from reset, extremes, a full-scale square burst,
		// then a clear with history in flight
		send_item(OP_CLEAR, 0, 1'b1);
		send_item(OP_FILTER, 0, 1'b0);
		repeat (3) send_item(OP_FILTER, FULL_POS, 1'b0);
		repeat (3) send_item(OP_FILTER, -FULL_POS - 1, 1'b0);
		send_item(OP_FILTER, 1, 1'b0);
		send_item(OP_FILTER, -1, 1'b0);
		send_item(OP_FILTER, 'h555555, 1'b0);
		send_item(OP_FILTER, 'hAAAAAA, 1'b1);
		for (int i = 0; i < 10; i++) begin
			send_item(OP_FILTER, (i < 5) ? FULL_POS : -FULL_POS - 1, i == 9);
		end
		send_item(OP_CLEAR, 'h123456, 1'b0);
		send_item(OP_FILTER, FULL_POS, 1'b1);
		drain_results();

		// random blocks, each run of filter items closed by last
		while (sent < ITEM_TARGET) begin
			kind  = $urandom_range(0, 99);
			span  = $urandom_range(5, 40);
			half  = $urandom_range(3, 15);
			level = $urandom_range(0, 1) ? FULL_POS : $urandom_range(1 << 20, FULL_POS);
			value = $urandom();
			if (kind >= 94) begin
				send_item(OP_CLEAR, $urandom(), $urandom_range(0, 1));
			end else begin
				for (int i = 0; i < span; i++) begin
					if (kind < 40) begin
						// full-scale noise
						value = $urandom();
					end else if (kind < 65) begin
						// square burst near the peak of the weighting curve
						value = ((i / half) % 2) ? -level - 1 : level;
					end else if (kind < 82) begin
						// quiet noise
						value = $urandom_range(0, 8191) - 4096;
					end
					// otherwise a DC run of the value drawn above
					send_item(OP_FILTER, value,
						(i == span - 1) || ($urandom_range(0, 19) == 0));
				end
			end
			if (!paused && sent >= 550) begin
				drain_results();
				paused = 1'b1;
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_total == 0 && outstanding == 0) begin
			$display("a_weighting_biquad_cascade_unit_test: clean");
		end else begin
			$display("a_weighting_biquad_cascade_unit_test: errors");
		end
		$finish;
	end

endmodule
